// ----- sv/z_encoding_symbol_decoder_defines.svh -----
// Assertion macros for the Z-encoding symbol decoder.
// Used by z_encoding_symbol_decoder.sv; expects clk and arst_n in scope.
`ifndef Z_ENCODING_SYMBOL_DECODER_DEFINES_SVH
`define Z_ENCODING_SYMBOL_DECODER_DEFINES_SVH

// same-cycle implication
`define ZSD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ZSD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/zsd_pkg.sv -----
// Package for the Z-encoding symbol decoder: decode modes, emit kinds,
// character codes and the escape lookup functions. No dependencies.
package zsd_pkg;

	localparam int          MAX_ARITY_DEF   = 60;
	localparam logic [7:0]  REPL_CHAR_RESET = 8'h7E;   // '~'

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BIG_Z  = 8'h5A;
	localparam logic [7:0] CH_SML_Z  = 8'h7A;
	localparam logic [7:0] CH_L      = 8'h4C;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_H      = 8'h48;
	localparam logic [7:0] CH_U      = 8'h55;

	typedef enum logic [4:0] {
		MODE_PLAIN  = 5'b00001,
		MODE_BIGZ   = 5'b00010,
		MODE_ARITY  = 5'b00100,
		MODE_SMALLZ = 5'b01000,
		MODE_HEX    = 5'b10000
	} mode_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_ONE,
		EMIT_TUP_T,
		EMIT_TUP_H
	} emit_t;

	// operator escape after 'z'; zero means no such escape
	function automatic logic [7:0] small_z_char(input logic [7:0] b);
		logic [7:0] c;
		case (b)
			8'h61: c = 8'h26;   // a &
			8'h62: c = 8'h7C;   // b |
			8'h63: c = 8'h5E;   // c ^
			8'h64: c = 8'h24;   // d $
			8'h65: c = 8'h3D;   // e =
			8'h67: c = 8'h3E;   // g >
			8'h68: c = 8'h23;   // h #
			8'h69: c = 8'h2E;   // i .
			8'h6C: c = 8'h3C;   // l <
			8'h6D: c = 8'h2D;   // m -
			8'h6E: c = 8'h21;   // n !
			8'h70: c = 8'h2B;   // p +
			8'h71: c = 8'h27;   // q '
			8'h72: c = 8'h5C;   // r backslash
			8'h73: c = 8'h2F;   // s /
			8'h74: c = 8'h2A;   // t *
			8'h75: c = 8'h5F;   // u _
			8'h76: c = 8'h25;   // v %
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	// {valid, value} of a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'b0;
		if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

endpackage

// ----- sv/z_encoding_symbol_decoder.sv -----
// Z-encoding symbol decoder: one encoded byte in per beat, decoded chars out.
// Depends on zsd_pkg and z_encoding_symbol_decoder_defines.svh.
//
//   channel | signals                              | dir
//   --------+--------------------------------------+-----
//   input   | in_valid, in_stall, in_byte,         | in
//           | end_of_symbol                        |
//   output  | out_valid, out_stall, out_char,      | out
//           | last, malformed                      |
//   config  | cfg_wr_en, cfg_wr_data               | in
//
// One byte enters the input register per cycle when in_stall is low; the
// decode between it and the output register makes one result per cycle unless
// out_stall holds it. A byte with n results (1 for most, up to 64 for a tuple
// closing a symbol) stays until its last is loaded, freeing the register in
// that cycle, so unstalled bytes with at most one result flow at one per cycle.
// arst_n clears control state and sets replacement char to '~'.
// out_stall holds the output register and, through it, the input stage.
`include "z_encoding_symbol_decoder_defines.svh"

module z_encoding_symbol_decoder
	import zsd_pkg::*;
#(
	parameter int MAX_ARITY = MAX_ARITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last,
	output logic       malformed
);

	logic [7:0] repl_q;
	mode_t      mode_q;
	logic [5:0] arity_q;
	logic [8:0] hex_q;
	logic       err_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic [5:0] idx_q;

	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       last_q;
	logic       malformed_q;

	// decode of the byte in the input register
	mode_t       mode_n;
	logic [5:0]  arity_n;
	logic [8:0]  hex_n;
	logic        fail_c;
	logic        err_n;
	logic        term_bad;
	emit_t       kind;
	logic [7:0]  one_char;
	logic        is_dig;
	logic [3:0]  dec;
	logic [4:0]  hexd;
	logic [7:0]  zc;
	logic [9:0]  arity_acc;
	logic [12:0] hex_acc;

	logic [5:0]  body_len;
	logic [6:0]  total;
	logic        is_term;
	logic        is_last_res;
	logic [7:0]  res_char;
	logic        out_ready;
	logic        emit_now;
	logic        retire;
	logic        in_take;

	always_comb begin
		is_dig    = (byte_s1 >= 8'h30) && (byte_s1 <= 8'h39);
		dec       = 4'(byte_s1 - 8'h30);
		hexd      = hex_digit(byte_s1);
		zc        = small_z_char(byte_s1);
		arity_acc = ({4'b0, arity_q} << 3) + ({4'b0, arity_q} << 1) + {6'b0, dec};
		hex_acc   = {hex_q, 4'b0} + {9'b0, hexd[3:0]};

		mode_n   = mode_q;
		arity_n  = arity_q;
		hex_n    = hex_q;
		fail_c   = 1'b0;
		kind     = EMIT_NONE;
		one_char = byte_s1;

		if (!err_q) begin
			if (byte_s1 == CH_NUL) begin
				fail_c = 1'b1;
			end else begin
				case (mode_q)
					MODE_PLAIN: begin
						if (byte_s1 == CH_BIG_Z)      mode_n = MODE_BIGZ;
						else if (byte_s1 == CH_SML_Z) mode_n = MODE_SMALLZ;
						else                          kind = EMIT_ONE;
					end
					MODE_BIGZ: begin
						mode_n = MODE_PLAIN;
						kind   = EMIT_ONE;
						case (byte_s1)
							CH_L:     one_char = CH_LPAREN;
							CH_R:     one_char = CH_RPAREN;
							CH_M:     one_char = CH_LBRACK;
							CH_N:     one_char = CH_RBRACK;
							CH_C:     one_char = CH_COLON;
							CH_BIG_Z: one_char = CH_BIG_Z;
							default: begin
								kind = EMIT_NONE;
								if (is_dig && ({6'b0, dec} <= 10'(MAX_ARITY))) begin
									arity_n = {2'b0, dec};
									mode_n  = MODE_ARITY;
								end else begin
									fail_c = 1'b1;
								end
							end
						endcase
					end
					MODE_ARITY: begin
						if (is_dig) begin
							if (arity_acc > 10'(MAX_ARITY)) fail_c = 1'b1;
							else                            arity_n = arity_acc[5:0];
						end else if (byte_s1 == CH_T || byte_s1 == CH_H) begin
							kind    = (byte_s1 == CH_T) ? EMIT_TUP_T : EMIT_TUP_H;
							mode_n  = MODE_PLAIN;
							arity_n = 6'd0;
						end else begin
							fail_c = 1'b1;
						end
					end
					MODE_SMALLZ: begin
						if (zc != CH_NUL) begin
							kind     = EMIT_ONE;
							one_char = zc;
							mode_n   = MODE_PLAIN;
						end else if (hexd[4]) begin
							hex_n  = {5'b0, hexd[3:0]};
							mode_n = MODE_HEX;
						end else begin
							fail_c = 1'b1;
						end
					end
					MODE_HEX: begin
						if (hexd[4]) begin
							hex_n = (hex_acc > 13'd255) ? 9'd256 : hex_acc[8:0];
						end else if (byte_s1 == CH_U) begin
							kind     = EMIT_ONE;
							one_char = hex_q[8] ? repl_q : hex_q[7:0];
							mode_n   = MODE_PLAIN;
							hex_n    = 9'd0;
						end else begin
							fail_c = 1'b1;
						end
					end
					default: fail_c = 1'b1;
				endcase
			end
		end

		if (fail_c) mode_n = MODE_PLAIN;
		err_n    = err_q | fail_c;
		term_bad = err_n | (mode_n != MODE_PLAIN);
	end

	// result run of the current byte: body chars, then terminator on symbol end
	always_comb begin
		case (kind)
			EMIT_NONE:  body_len = 6'd0;
			EMIT_ONE:   body_len = 6'd1;
			EMIT_TUP_T: body_len = (arity_q <= 6'd1) ? 6'd2 : arity_q + 6'd1;
			EMIT_TUP_H: body_len = (arity_q <= 6'd1) ? arity_q + 6'd4 : arity_q + 6'd3;
			default:    body_len = 6'd0;
		endcase
		total       = {1'b0, body_len} + {6'b0, end_s1};
		is_term     = (idx_q == body_len);
		is_last_res = ({1'b0, idx_q} == total - 7'd1);

		case (kind)
			EMIT_TUP_T: begin
				if (idx_q == 6'd0)                  res_char = CH_LPAREN;
				else if (idx_q == body_len - 6'd1)  res_char = CH_RPAREN;
				else                                res_char = CH_COMMA;
			end
			EMIT_TUP_H: begin
				if (idx_q == 6'd0)                  res_char = CH_LPAREN;
				else if (idx_q == 6'd1)             res_char = CH_HASH;
				else if (idx_q == body_len - 6'd2)  res_char = CH_HASH;
				else if (idx_q == body_len - 6'd1)  res_char = CH_RPAREN;
				else if (arity_q == 6'd1)           res_char = CH_SPACE;
				else                                res_char = CH_COMMA;
			end
			EMIT_ONE: res_char = one_char;
			default:  res_char = CH_NUL;
		endcase
		if (is_term) res_char = CH_NUL;
	end

	assign out_ready = !out_valid_q || !out_stall;
	assign emit_now  = valid_s1 && (total != 7'd0) && out_ready;
	assign retire    = valid_s1 && ((total == 7'd0) || (out_ready && is_last_res));
	assign in_stall  = valid_s1 && !retire;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= REPL_CHAR_RESET;
		end else if (cfg_wr_en) begin
			repl_q <= cfg_wr_data;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= 6'd0;
		end else begin
			if (in_take)     valid_s1 <= 1'b1;
			else if (retire) valid_s1 <= 1'b0;
			if (retire)        idx_q <= 6'd0;
			else if (emit_now) idx_q <= idx_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= in_byte;
			end_s1  <= end_of_symbol;
		end
	end

	// symbol state advances once per byte, when it leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PLAIN;
			arity_q <= 6'd0;
			hex_q   <= 9'd0;
			err_q   <= 1'b0;
		end else if (retire) begin
			if (end_s1) begin
				mode_q  <= MODE_PLAIN;
				arity_q <= 6'd0;
				hex_q   <= 9'd0;
				err_q   <= 1'b0;
			end else begin
				mode_q  <= mode_n;
				arity_q <= arity_n;
				hex_q   <= hex_n;
				err_q   <= err_n;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= emit_now;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			out_char_q  <= res_char;
			last_q      <= is_term;
			malformed_q <= is_term && term_bad;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;
	assign malformed = malformed_q;

	`ZSD_ASSERT_IMP(a_arity_limit, 1'b1, arity_q <= 6'(MAX_ARITY), "arity above limit")
	`ZSD_ASSERT_IMP(a_hex_sat, 1'b1, hex_q <= 9'd256, "code point not saturated")
	`ZSD_ASSERT_IMP(a_err_plain, err_q, mode_q == MODE_PLAIN, "escape open after error")
	`ZSD_ASSERT_NXT(a_term_load, emit_now && is_term, out_valid_q && last_q && (out_char_q == CH_NUL), "terminator not loaded")

endmodule
